// ----- design/fir_reverb_predelay_mix_macros.svh -----
// Assertion macros shared by the reverb block.
`ifndef FIR_REVERB_PREDELAY_MIX_MACROS_SVH
`define FIR_REVERB_PREDELAY_MIX_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FRPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FRPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/frpm_pkg.sv -----
// Package: types, constants and helpers for the reverb block.
package frpm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int MAX_TAPS    = 512;
  localparam int TAP_AW      = $clog2(MAX_TAPS);
  localparam int TAP_CW      = TAP_AW + 1;
  localparam int TM_AW       = TAP_AW + 1;
  localparam int PD_DEPTH    = 8192;
  localparam int PD_AW       = $clog2(PD_DEPTH);
  localparam int PD_CW       = PD_AW + 1;
  localparam int MIX_ONE     = 65536;
  localparam int MIX_W       = 17;
  localparam int MIX_SHIFT   = 16;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + TAP_AW;
  localparam int MPROD_W     = SAMPLE_BITS + MIX_W + 1;
  localparam int MSUM_W      = MPROD_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREDELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd2;

  // Input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                    command;
    logic [TAP_AW-1:0]       tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic signed [SAMPLE_BITS-1:0] wet_sample;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PD_RD,
    ST_HIST_WR,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_C,
    ST_FIN
  } state_t;

  // Clamp a wide signed value to the sample range
  function automatic sample_t sat_sample(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd1 <<< FRAC_BITS;
    hi = hi - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return sample_t'(v);
  endfunction

endpackage

// ----- design/fir_reverb_predelay_mix.sv -----
// Mono convolution reverb: pre-delay line, tap memory FIR and dry/wet mix.
//
// Input channel (in_valid/in_ready/in_data) carries two kinds of word. A load
// word writes one coefficient and finishes in the cycle it is accepted; it
// gives no result. A sample word goes through the pre-delay line, enters the
// tap history and runs the FIR, then gives one result word (mixed, wet) on
// out_valid/out_ready.
// The next word is accepted only once a sample has finished; how long that takes
// is set by the single multiply-accumulate unit, which reads one
// history entry and one coefficient from the tap memory each cycle.
// Results sit in an output register: the block accepts the next word while a
// result waits, and only holds its final step when a second result is ready
// and the first has not been taken.
// Config (cfg_we/cfg_index/cfg_data) must be written only while idle, which the block
// does not enforce: 0 mix gain Q1.16, 1 pre-delay in samples, 2 tap count.
// After reset the tap memory (history and coefficients, 1024 entries) is cleared,
// one entry a cycle, with in_ready low; config writes are taken then.
// The pre-delay line tracks how far it has been filled and reads zero beyond.
module fir_reverb_predelay_mix (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  frpm_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output frpm_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [frpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import frpm_pkg::*;

  // Config registers
  logic [MIX_W-1:0]  mix_gain_r;
  logic [PD_AW-1:0]  predelay_r;
  logic [TAP_CW-1:0] tap_count_r;

  // Control state
  state_t            state_r, state_nxt;
  logic              clr_r;
  logic [TM_AW-1:0]  clr_cnt_r;
  logic [PD_AW-1:0]  wp_r;
  logic [PD_CW-1:0]  fill_r;
  logic [TAP_AW-1:0] head_r;
  logic [TAP_CW-1:0] mac_cnt_r;
  logic              rd_v_r;
  logic              prod_v_r;
  logic              out_valid_r;

  // Datapath registers
  sample_t                   dry_r;
  sample_t                   delayed_r;
  logic                      pd_zero_r;
  logic                      pd_ok_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  sample_t                   wet_r;
  sample_t                   mixed_r;
  logic signed [MPROD_W-1:0] p1_r;
  logic signed [MPROD_W-1:0] p2_r;
  out_word_t                 out_data_r;

  // Memories
  sample_t pd_mem [PD_DEPTH];
  sample_t tm_mem [2 * MAX_TAPS];
  sample_t pd_rdata_r;
  sample_t tm_rdata_a_r;
  sample_t tm_rdata_b_r;

  // Control signals
  logic              accept;
  logic              pd_we;
  logic [PD_AW-1:0]  pd_raddr;
  logic              tm_we;
  logic [TM_AW-1:0]  tm_waddr;
  sample_t           tm_wdata;
  logic [TM_AW-1:0]  tm_raddr_a;
  logic [TM_AW-1:0]  tm_raddr_b;
  logic              fin_load;

  // Clamped config values
  logic [PD_AW-1:0]  d_eff;
  logic [TAP_CW-1:0] taps_eff;
  logic [MIX_W-1:0]  g_eff;
  logic signed [MIX_W:0] g_wet;
  logic signed [MIX_W:0] g_dry;

  // Rounding and mix sums
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [MSUM_W-1:0] mix_sum;

  always_comb begin
    d_eff = (predelay_r > PD_AW'(PD_DEPTH - 1)) ? PD_AW'(PD_DEPTH - 1) : predelay_r;
    taps_eff = (tap_count_r > TAP_CW'(MAX_TAPS)) ? TAP_CW'(MAX_TAPS) : tap_count_r;
    g_eff = (mix_gain_r > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : mix_gain_r;
    g_wet = $signed({1'b0, g_eff});
    g_dry = $signed({1'b0, MIX_W'(MIX_ONE) - g_eff});
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_gain_r  <= '0;
      predelay_r  <= '0;
      tap_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIX_GAIN:  mix_gain_r  <= cfg_data[MIX_W-1:0];
        CFG_PREDELAY:  predelay_r  <= cfg_data[PD_AW-1:0];
        CFG_TAP_COUNT: tap_count_r <= cfg_data[TAP_CW-1:0];
        default:       ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.command == CMD_SAMPLE) begin
          state_nxt = ST_PD_RD;
        end
      end
      ST_PD_RD:   state_nxt = ST_HIST_WR;
      ST_HIST_WR: state_nxt = (taps_eff == '0) ? ST_FIN : ST_MAC;
      ST_MAC: begin
        if (mac_cnt_r == taps_eff - TAP_CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_MIX_A;
      ST_MIX_A: state_nxt = ST_MIX_B;
      ST_MIX_B: state_nxt = ST_MIX_C;
      ST_MIX_C: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory port control
  always_comb begin
    in_ready = (state_r == ST_IDLE) && !clr_r;
    accept   = in_valid && in_ready;
    fin_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    pd_we    = accept && (in_data.command == CMD_SAMPLE);
    pd_raddr = wp_r - d_eff;
    tm_we    = clr_r || (accept && in_data.command == CMD_LOAD) || (state_r == ST_HIST_WR);
    if (clr_r) begin
      tm_waddr = clr_cnt_r;
      tm_wdata = '0;
    end else if (state_r == ST_HIST_WR) begin
      tm_waddr = {1'b0, head_r + TAP_AW'(1)};
      tm_wdata = delayed_r;
    end else begin
      tm_waddr = {1'b1, in_data.tap_index};
      tm_wdata = in_data.value;
    end
    tm_raddr_a = {1'b0, head_r - mac_cnt_r[TAP_AW-1:0]};
    tm_raddr_b = {1'b1, mac_cnt_r[TAP_AW-1:0]};
  end

  // Pre-delay line: write at the head, registered read behind it
  always_ff @(posedge clk) begin
    if (pd_we) begin
      pd_mem[wp_r] <= in_data.value;
    end
    pd_rdata_r <= pd_mem[pd_raddr];
  end

  // Tap memory: lower half history, upper half coefficients
  always_ff @(posedge clk) begin
    if (tm_we) begin
      tm_mem[tm_waddr] <= tm_wdata;
    end
    tm_rdata_a_r <= tm_mem[tm_raddr_a];
    tm_rdata_b_r <= tm_mem[tm_raddr_b];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      mac_cnt_r   <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + TM_AW'(1);
        if (clr_cnt_r == TM_AW'(2 * MAX_TAPS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (pd_we) begin
        wp_r <= wp_r + PD_AW'(1);
        if (fill_r != PD_CW'(PD_DEPTH)) begin
          fill_r <= fill_r + PD_CW'(1);
        end
      end
      if (state_r == ST_HIST_WR) begin
        head_r    <= head_r + TAP_AW'(1);
        mac_cnt_r <= '0;
      end else if (state_r == ST_MAC) begin
        mac_cnt_r <= mac_cnt_r + TAP_CW'(1);
      end
      rd_v_r   <= (state_r == ST_MAC);
      prod_v_r <= rd_v_r;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Round the accumulator to Q1.23, mix sum with half-LSB offset
  always_comb begin
    acc_rnd = acc_r + (ACC_W'(1) <<< (FRAC_BITS - 1));
    mix_sum = MSUM_W'(p1_r) + MSUM_W'(p2_r) + (MSUM_W'(1) <<< (MIX_SHIFT - 1));
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      dry_r     <= in_data.value;
      pd_zero_r <= (d_eff == '0);
      pd_ok_r   <= (fill_r >= PD_CW'(d_eff));
    end
    if (state_r == ST_PD_RD) begin
      if (pd_zero_r) begin
        delayed_r <= dry_r;
      end else if (pd_ok_r) begin
        delayed_r <= pd_rdata_r;
      end else begin
        delayed_r <= '0;
      end
    end
    // one product per cycle, accumulated in the cycle after
    prod_r <= tm_rdata_a_r * tm_rdata_b_r;
    if (state_r == ST_HIST_WR) begin
      acc_r   <= '0;
      wet_r   <= '0;
      mixed_r <= dry_r;
    end else begin
      if (prod_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (state_r == ST_ROUND) begin
        wet_r <= sat_sample(64'(acc_rnd >>> FRAC_BITS));
      end
      if (state_r == ST_MIX_C) begin
        mixed_r <= sat_sample(64'(mix_sum >>> MIX_SHIFT));
      end
    end
    if (state_r == ST_MIX_A) begin
      p1_r <= dry_r * g_dry;
    end
    if (state_r == ST_MIX_B) begin
      p2_r <= wet_r * g_wet;
    end
    if (fin_load) begin
      out_data_r.mixed_sample <= mixed_r;
      out_data_r.wet_sample   <= wet_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "fir_reverb_predelay_mix_macros.svh"

  `FRPM_ASSERT_NOW(a_no_accept_in_clear, clr_r, !in_ready, "word accepted during clear pass")
  `FRPM_ASSERT_NEXT(a_fin_holds, (state_r == ST_FIN) && out_valid_r && !out_ready, state_r == ST_FIN, "result overwrote waiting word")
  `FRPM_ASSERT_NOW(a_mac_in_range, state_r == ST_MAC, mac_cnt_r < taps_eff, "tap counter past tap count")
  `FRPM_ASSERT_NOW(a_no_write_in_mac, state_r == ST_MAC, !tm_we, "tap memory written during MAC walk")
  `FRPM_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= PD_CW'(PD_DEPTH), "pre-delay fill count past depth")

endmodule
